[hw/rtl/adl_pkg.sv]
// Shared types and constants for the ADC average and distance linearizer.
// Holds field widths, range status codes and the calibration breakpoint table.
// No dependencies; compiled first.
`timescale 1ns / 1ps
`default_nettype none

package adl_pkg;

  // Field widths of the item channels.
  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned MV_W     = 12;
  localparam int unsigned DIST_W   = 12;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 8;

  // Configuration port.
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned REG_AVG_COUNT = 0;

  // Conversion and clamp constants.
  localparam logic [MV_W-1:0]   FULL_SCALE_MV = 12'd3300;
  localparam logic [MV_W-1:0]   MIN_VALID_MV  = 12'd300;
  localparam logic [DIST_W-1:0] FAR_Q8        = 12'd3840;

  // Calibration breakpoints, voltage falling as distance grows.
  localparam int unsigned TABLE_POINTS = 13;
  localparam int unsigned SEG_W = $clog2(TABLE_POINTS);

  localparam logic [MV_W-1:0] CAL_MV [TABLE_POINTS] = '{
    12'd1890, 12'd1550, 12'd1240, 12'd1050, 12'd860, 12'd740, 12'd710,
    12'd630, 12'd560, 12'd470, 12'd430, 12'd370, 12'd330
  };

  localparam logic [DIST_W-1:0] CAL_Q8 [TABLE_POINTS] = '{
    12'd512, 12'd768, 12'd1024, 12'd1280, 12'd1536, 12'd1792, 12'd2048,
    12'd2304, 12'd2560, 12'd2816, 12'd3072, 12'd3328, 12'd3584
  };

  // Range status codes carried with each result item.
  typedef enum logic [STATUS_W-1:0] {
    RANGE_INTERP = 2'd0,
    RANGE_NEAR   = 2'd1,
    RANGE_FAR    = 2'd2
  } range_status_e;

endpackage

`default_nettype wire

[hw/rtl/adl_if.sv]
// Valid/ready item channels of the ADC average and distance linearizer.
// Depends on adl_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

// Input channel: one raw converter sample per item.
interface adl_in_if;
  import adl_pkg::*;

  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] adc_sample;

  modport source (output valid, output adc_sample, input ready);
  modport sink   (input valid, input adc_sample, output ready);
endinterface

// Output channel: one averaged and linearized result per item.
interface adl_out_if;
  import adl_pkg::*;

  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] avg_raw;
  logic [MV_W-1:0]     voltage_mv;
  logic [DIST_W-1:0]   distance_q8;
  logic [STATUS_W-1:0] range_status;

  modport source (output valid, output avg_raw, output voltage_mv,
                  output distance_q8, output range_status, input ready);
  modport sink   (input valid, input avg_raw, input voltage_mv,
                  input distance_q8, input range_status, output ready);
endinterface

`default_nettype wire

[hw/rtl/adl_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
// Shared by the average and interpolation divisions of the linearizer; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

module adl_div #(
  parameter int unsigned W = 24
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [W-1:0] dividend_i,
  input  wire logic [W-1:0] divisor_i,
  output logic              done_o,
  output logic [W-1:0]      quotient_o
);

  localparam int unsigned CNT_W = $clog2(W + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             zero_q, zero_d;
  logic [W-1:0]     rem_q, rem_d;
  logic [W-1:0]     quo_q, quo_d;
  logic [W-1:0]     dsr_q, dsr_d;
  logic [W:0]       trial;
  logic [W:0]       diff;
  logic             fits;

  // Trial subtraction of the divisor from the shifted partial remainder.
  always_comb begin
    trial = {rem_q, quo_q[W-1]};
    diff  = trial - {1'b0, dsr_q};
    fits  = (trial >= {1'b0, dsr_q});
  end

  // Iteration control and datapath next values.
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    zero_d = zero_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(W);
      zero_d = (divisor_i == '0);
      rem_d  = '0;
      quo_d  = dividend_i;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = fits ? diff[W-1:0] : trial[W-1:0];
      quo_d = {quo_q[W-2:0], fits};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    zero_q <= zero_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    dsr_q  <= dsr_d;
  end

  // A zero divisor yields a zero quotient.
  assign done_o     = done_q;
  assign quotient_o = zero_q ? '0 : quo_q;

endmodule

`default_nettype wire

[hw/rtl/adc_average_distance_linearizer.sv]
// Top level of the ADC average and distance linearizer.
// Depends on adl_pkg, the adl_in_if / adl_out_if channels and adl_div.
//
//   Channel   Role      Handshake       Payload
//   in_i      sink      valid/ready     adc_sample
//   out_o     source    valid/ready     avg_raw, voltage_mv, distance_q8, range_status
//   APB       slave     psel/penable    avg_count at byte address 0
//
// A sample that does not close a group is only accumulated. A sample that
// closes a group runs the shared one-bit-per-cycle divider twice (average, then
// interpolation). In between, the millivolt product is divided by
// 2^ADC_BITS - 1 by folding its high part into its low part, one add per cycle.
// Clamped voltages skip the second division.
// The input is not ready during that work, nor while the finished result waits
// for a full output register to drain. Otherwise the result sits in the output
// register, so new samples are taken while it waits for the sink.
// Reset clears the accumulator and sets avg_count to one.
`timescale 1ns / 1ps
`default_nettype none

module adc_average_distance_linearizer #(
  parameter int unsigned ADC_BITS = 12
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  adl_in_if.sink                               in_i,
  adl_out_if.source                            out_o,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [adl_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire logic [adl_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [adl_pkg::APB_DATA_W-1:0]       prdata,
  output logic                                 pready
);

  import adl_pkg::*;

  localparam int unsigned SUM_W = ADC_BITS + COUNT_W;
  localparam int unsigned MVP_W = ADC_BITS + MV_W;
  localparam int unsigned IPP_W = MV_W + DIST_W;
  localparam int unsigned DIV_W = (SUM_W > IPP_W) ? SUM_W : IPP_W;
  localparam logic [ADC_BITS-1:0] ADC_ONES   = '1;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MSK = SAMPLE_W'((64'd1 << ADC_BITS) - 64'd1);

  // Sequencer states.
  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_DIV_AVG = 3'd1;
  localparam logic [2:0] ST_MUL_MV  = 3'd2;
  localparam logic [2:0] ST_FOLD_MV = 3'd3;
  localparam logic [2:0] ST_SEG     = 3'd4;
  localparam logic [2:0] ST_MUL_IP  = 3'd5;
  localparam logic [2:0] ST_DIV_IP  = 3'd6;
  localparam logic [2:0] ST_DONE    = 3'd7;

  logic [2:0]          state_q, state_d;
  logic [COUNT_W-1:0]  avg_count_q, avg_count_d;
  logic [SUM_W-1:0]    sum_q, sum_d;
  logic [COUNT_W-1:0]  cnt_q, cnt_d;
  logic [ADC_BITS-1:0] avg_q, avg_d;
  logic [MVP_W-1:0]    fold_rem_q, fold_rem_d;
  logic [MV_W-1:0]     fold_quo_q, fold_quo_d;
  logic [MV_W-1:0]     mv_q, mv_d;
  logic [MV_W-1:0]     diff_q, diff_d;
  logic [DIST_W-1:0]   step_q, step_d;
  logic [MV_W-1:0]     den_q, den_d;
  logic [DIST_W-1:0]   d1_q, d1_d;
  logic [DIST_W-1:0]   dist_q, dist_d;
  range_status_e       status_q, status_d;

  logic                out_valid_q, out_valid_d;
  logic [SAMPLE_W-1:0] out_avg_q, out_avg_d;
  logic [MV_W-1:0]     out_mv_q, out_mv_d;
  logic [DIST_W-1:0]   out_dist_q, out_dist_d;
  range_status_e       out_status_q, out_status_d;

  logic                in_fire;
  logic                cfg_wr;
  logic [COUNT_W-1:0]  group_n;
  logic [COUNT_W-1:0]  cnt_next;
  logic [SUM_W-1:0]    sum_next;
  logic                group_done;
  logic                out_free;

  logic [MVP_W-1:0]    mv_prod;
  logic [MV_W-1:0]     fold_hi;
  logic [ADC_BITS-1:0] fold_lo;
  logic [IPP_W-1:0]    ip_prod;
  logic [SEG_W-1:0]    seg_k;
  logic                seg_found;
  logic                seg_far;
  logic                seg_near;
  logic [MV_W-1:0]     seg_v1;
  logic [MV_W-1:0]     seg_v2;
  logic [DIST_W-1:0]   seg_d1;
  logic [DIST_W-1:0]   seg_d2;

  logic                div_start;
  logic [DIV_W-1:0]    div_dividend;
  logic [DIV_W-1:0]    div_divisor;
  logic                div_done;
  logic [DIV_W-1:0]    div_quo;

  // Configuration port: single register, no wait states.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[APB_ADDR_W-1] == 1'b0);
  assign prdata = (paddr[APB_ADDR_W-1] == 1'b0) ? APB_DATA_W'(avg_count_q) : '0;
  assign avg_count_d = cfg_wr ? pwdata[COUNT_W-1:0] : avg_count_q;

  // Accumulation of one sample and the group-complete test.
  assign in_fire    = in_i.valid && in_i.ready;
  assign group_n    = (avg_count_q == '0) ? COUNT_W'(1) : avg_count_q;
  assign cnt_next   = cnt_q + COUNT_W'(1);
  assign sum_next   = sum_q + SUM_W'(in_i.adc_sample & SAMPLE_MSK);
  assign group_done = (cnt_next >= group_n) || (cnt_next == '0);
  assign out_free   = !out_valid_q || out_o.ready;

  // Products; the millivolt product is folded, the other feeds the divider.
  assign mv_prod = avg_q * FULL_SCALE_MV;
  assign ip_prod = diff_q * step_q;

  // Split of the running remainder at 2^ADC_BITS for the millivolt fold.
  assign fold_hi = fold_rem_q[MVP_W-1:ADC_BITS];
  assign fold_lo = fold_rem_q[ADC_BITS-1:0];

  // Segment search over the breakpoints: first one the voltage reaches.
  always_comb begin
    seg_k     = '0;
    seg_found = 1'b0;
    for (int k = 0; k < TABLE_POINTS - 1; k++) begin
      if (!seg_found && (mv_q >= CAL_MV[k+1])) begin
        seg_k     = SEG_W'(k);
        seg_found = 1'b1;
      end
    end
    seg_far  = (mv_q < MIN_VALID_MV) || (mv_q <= CAL_MV[TABLE_POINTS-1]);
    seg_near = (mv_q >= CAL_MV[0]);
    seg_v1   = CAL_MV[seg_k];
    seg_v2   = CAL_MV[seg_k + SEG_W'(1)];
    seg_d1   = CAL_Q8[seg_k];
    seg_d2   = CAL_Q8[seg_k + SEG_W'(1)];
  end

  // Sequencer and datapath next values.
  always_comb begin
    state_d      = state_q;
    sum_d        = sum_q;
    cnt_d        = cnt_q;
    avg_d        = avg_q;
    fold_rem_d   = fold_rem_q;
    fold_quo_d   = fold_quo_q;
    mv_d         = mv_q;
    diff_d       = diff_q;
    step_d       = step_q;
    den_d        = den_q;
    d1_d         = d1_q;
    dist_d       = dist_q;
    status_d     = status_q;
    div_start    = 1'b0;
    div_dividend = DIV_W'(sum_next);
    div_divisor  = DIV_W'(cnt_next);
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (group_done) begin
            sum_d     = '0;
            cnt_d     = '0;
            div_start = 1'b1;
            state_d   = ST_DIV_AVG;
          end else begin
            sum_d = sum_next;
            cnt_d = cnt_next;
          end
        end
      end
      ST_DIV_AVG: begin
        if (div_done) begin
          avg_d   = ADC_BITS'(div_quo);
          state_d = ST_MUL_MV;
        end
      end
      ST_MUL_MV: begin
        fold_rem_d = mv_prod;
        fold_quo_d = '0;
        state_d    = ST_FOLD_MV;
      end
      ST_FOLD_MV: begin
        // Each 2^ADC_BITS in the remainder is one divisor plus one left over.
        if (fold_hi != '0) begin
          fold_quo_d = fold_quo_q + fold_hi;
          fold_rem_d = MVP_W'(fold_lo) + MVP_W'(fold_hi);
        end else if (fold_lo == ADC_ONES) begin
          fold_quo_d = fold_quo_q + MV_W'(1);
          fold_rem_d = '0;
        end else begin
          mv_d    = fold_quo_q;
          state_d = ST_SEG;
        end
      end
      ST_SEG: begin
        if (seg_far) begin
          dist_d   = FAR_Q8;
          status_d = RANGE_FAR;
          state_d  = ST_DONE;
        end else if (seg_near) begin
          dist_d   = CAL_Q8[0];
          status_d = RANGE_NEAR;
          state_d  = ST_DONE;
        end else begin
          diff_d  = seg_v1 - mv_q;
          den_d   = seg_v1 - seg_v2;
          step_d  = (seg_d2 >= seg_d1) ? (seg_d2 - seg_d1) : '0;
          d1_d    = seg_d1;
          state_d = ST_MUL_IP;
        end
      end
      ST_MUL_IP: begin
        div_start    = 1'b1;
        div_dividend = DIV_W'(ip_prod);
        div_divisor  = DIV_W'(den_q);
        state_d      = ST_DIV_IP;
      end
      ST_DIV_IP: begin
        if (div_done) begin
          dist_d   = DIST_W'(DIV_W'(d1_q) + div_quo);
          status_d = RANGE_INTERP;
          state_d  = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output register: loads when the result is done and the slot is free.
  always_comb begin
    out_valid_d  = out_valid_q;
    out_avg_d    = out_avg_q;
    out_mv_d     = out_mv_q;
    out_dist_d   = out_dist_q;
    out_status_d = out_status_q;
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if ((state_q == ST_DONE) && out_free) begin
      out_valid_d  = 1'b1;
      out_avg_d    = SAMPLE_W'(avg_q);
      out_mv_d     = mv_q;
      out_dist_d   = dist_q;
      out_status_d = status_q;
    end
  end

  // Shared divider.
  adl_div #(
    .W(DIV_W)
  ) u_adl_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // Control state and architectural state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      avg_count_q <= COUNT_W'(1);
      sum_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      avg_count_q <= avg_count_d;
      sum_q       <= sum_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    avg_q        <= avg_d;
    fold_rem_q   <= fold_rem_d;
    fold_quo_q   <= fold_quo_d;
    mv_q         <= mv_d;
    diff_q       <= diff_d;
    step_q       <= step_d;
    den_q        <= den_d;
    d1_q         <= d1_d;
    dist_q       <= dist_d;
    status_q     <= status_d;
    out_avg_q    <= out_avg_d;
    out_mv_q     <= out_mv_d;
    out_dist_q   <= out_dist_d;
    out_status_q <= out_status_d;
  end

  // Channel outputs.
  assign in_i.ready         = (state_q == ST_IDLE);
  assign out_o.valid        = out_valid_q;
  assign out_o.avg_raw      = out_avg_q;
  assign out_o.voltage_mv   = out_mv_q;
  assign out_o.distance_q8  = out_dist_q;
  assign out_o.range_status = out_status_q;

endmodule

`default_nettype wire

[hw/rtl/adl_checker.sv]
// Port-level checks for the ADC average and distance linearizer.
// Depends on adl_pkg; bound to the top level at the end of this file.
`timescale 1ns / 1ps
`default_nettype none

module adl_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          out_valid_i,
  input wire logic                          out_ready_i,
  input wire logic [adl_pkg::SAMPLE_W-1:0]  out_avg_raw_i,
  input wire logic [adl_pkg::MV_W-1:0]      out_voltage_mv_i,
  input wire logic [adl_pkg::DIST_W-1:0]    out_distance_q8_i,
  input wire logic [adl_pkg::STATUS_W-1:0]  out_range_status_i
);

  import adl_pkg::*;

  // A result item stays offered until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result item dropped before it was taken");

  // A stalled result item keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_distance_q8_i) &&
      $stable(out_voltage_mv_i) && $stable(out_avg_raw_i) && $stable(out_range_status_i))
    else $error("stalled result item changed");

  // Clamped results carry the end distances and a voltage beyond the table.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_range_status_i == RANGE_NEAR) |->
      (out_distance_q8_i == CAL_Q8[0]) && (out_voltage_mv_i >= CAL_MV[0]))
    else $error("near clamp inconsistent with voltage or distance");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_range_status_i == RANGE_FAR) |->
      (out_distance_q8_i == FAR_Q8) && (out_voltage_mv_i <= CAL_MV[TABLE_POINTS-1]))
    else $error("far clamp inconsistent with voltage or distance");

  // Interpolated results lie inside the calibrated span.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_range_status_i == RANGE_INTERP) |->
      (out_voltage_mv_i < CAL_MV[0]) && (out_voltage_mv_i > CAL_MV[TABLE_POINTS-1]) &&
      (out_distance_q8_i >= CAL_Q8[0]) &&
      (out_distance_q8_i <= CAL_Q8[TABLE_POINTS-1]))
    else $error("interpolated result outside the calibrated span");

endmodule

bind adc_average_distance_linearizer adl_checker u_adl_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .out_valid_i        (out_o.valid),
  .out_ready_i        (out_o.ready),
  .out_avg_raw_i      (out_o.avg_raw),
  .out_voltage_mv_i   (out_o.voltage_mv),
  .out_distance_q8_i  (out_o.distance_q8),
  .out_range_status_i (out_o.range_status)
);

`default_nettype wire

[dv/adc_average_distance_linearizer_tb.sv]
// Self-checking testbench for the ADC average and distance linearizer.
// Depends on adl_pkg, the adl_in_if / adl_out_if channels and the block itself.
// A scoreboard class predicts each averaged, linearized result item and checks it.
`timescale 1ns / 1ps

module adc_average_distance_linearizer_tb;
  import adl_pkg::*;

  localparam int unsigned CLK_HALF      = 5;
  localparam int unsigned RESET_CYCLES  = 7;
  localparam int unsigned SETTLE_CYCLES = 120;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned IDLE_PCT      = 12;
  localparam int unsigned REPORT_LIMIT  = 10;
  localparam int unsigned PHASE_ITEMS   = 40;

  // Byte addresses on the configuration port; index one holds no register.
  localparam logic [APB_ADDR_W-1:0] AVG_COUNT_ADDR = APB_ADDR_W'(REG_AVG_COUNT * 4);
  localparam logic [APB_ADDR_W-1:0] UNUSED_ADDR    = APB_ADDR_W'(4);

  typedef struct packed {
    logic [SAMPLE_W-1:0] avg_raw;
    logic [MV_W-1:0]     voltage_mv;
    logic [DIST_W-1:0]   distance_q8;
    range_status_e       status;
  } distance_result_t;

  // Predicts result items from accepted samples and checks what the block sends.
  class distance_scoreboard;
    logic [7:0]       avg_count;
    logic [19:0]      sample_sum;
    logic [7:0]       sample_count;
    distance_result_t expected_q[$];
    int unsigned      errors;
    int unsigned      samples_seen;
    int unsigned      results_seen;
    int unsigned      status_hits[3];
    int unsigned      breakpoint_mv[13];
    int unsigned      breakpoint_q8[13];

    function new();
      breakpoint_mv = '{1890, 1550, 1240, 1050, 860, 740, 710, 630, 560, 470, 430, 370, 330};
      for (int k = 0; k < 13; k++) begin
        breakpoint_q8[k] = (k + 2) * 256;
      end
      avg_count = 8'd1;
      sample_sum = '0;
      sample_count = '0;
      errors = 0;
      samples_seen = 0;
      results_seen = 0;
      status_hits = '{0, 0, 0};
    endfunction

    function void write_avg_count(logic [31:0] value);
      avg_count = value[7:0];
    endfunction

    // Maps millivolts onto the calibration curve.
    function void linearize(input int unsigned mv, output int unsigned dist_q8,
                            output range_status_e status);
      dist_q8 = 15 * 256;
      status = RANGE_FAR;
      if (mv < 300 || mv <= breakpoint_mv[12]) return;
      if (mv >= breakpoint_mv[0]) begin
        dist_q8 = breakpoint_q8[0];
        status = RANGE_NEAR;
        return;
      end
      for (int k = 0; k + 1 < 13; k++) begin
        if (mv <= breakpoint_mv[k] && mv >= breakpoint_mv[k + 1]) begin
          dist_q8 = breakpoint_q8[k] + ((breakpoint_mv[k] - mv) *
                    (breakpoint_q8[k + 1] - breakpoint_q8[k])) /
                    (breakpoint_mv[k] - breakpoint_mv[k + 1]);
          status = RANGE_INTERP;
          return;
        end
      end
    endfunction

    // Accumulates one accepted sample; a completed group queues one result.
    function void note_sample(logic [SAMPLE_W-1:0] sample);
      int unsigned      group_size;
      int unsigned      avg;
      int unsigned      mv;
      int unsigned      dist_q8;
      range_status_e    status;
      distance_result_t want;
      samples_seen++;
      group_size = (avg_count == 8'd0) ? 1 : avg_count;
      sample_sum = sample_sum + sample;
      sample_count = sample_count + 8'd1;
      if (sample_count < group_size && sample_count != 8'd0) return;
      avg = (sample_count != 8'd0) ? sample_sum / sample_count : 0;
      avg = avg & 32'hFFF;
      mv = (avg * 3300) / 4095;
      linearize(mv, dist_q8, status);
      want.avg_raw = avg[11:0];
      want.voltage_mv = mv[11:0];
      want.distance_q8 = dist_q8[11:0];
      want.status = status;
      expected_q.push_back(want);
      sample_sum = '0;
      sample_count = '0;
    endfunction

    function void report(string what, distance_result_t want, distance_result_t got);
      errors++;
      if (errors <= REPORT_LIMIT) begin
        $display("[%0t] %s: expected avg %0d mv %0d dist %0d status %0d,",
                 $realtime, what, want.avg_raw, want.voltage_mv, want.distance_q8,
                 want.status);
        $display("    got avg %0d mv %0d dist %0d status %0d",
                 got.avg_raw, got.voltage_mv, got.distance_q8, got.status);
      end
    endfunction

    // Compares one result item with the oldest prediction.
    function void check_result(distance_result_t got);
      distance_result_t want;
      if (expected_q.size() == 0) begin
        report("result item with nothing pending", got, got);
        return;
      end
      want = expected_q.pop_front();
      results_seen++;
      status_hits[want.status]++;
      if (got.avg_raw !== want.avg_raw || got.voltage_mv !== want.voltage_mv ||
          got.distance_q8 !== want.distance_q8 || got.status !== want.status) begin
        report("result mismatch", want, got);
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // Anything still queued at the end never arrived.
    function void flush_check();
      while (expected_q.size() != 0) begin
        report("result item never arrived", expected_q[0], '0);
        void'(expected_q.pop_front());
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  // Shared between the sender and the receiver: steady turns idling off and
  // each new hold request starts one long receiver hold-off.
  logic        steady;
  int unsigned hold_reqs;
  int unsigned settings_used;

  distance_scoreboard sb = new();

  adl_in_if  in_if ();
  adl_out_if out_if ();

  adc_average_distance_linearizer uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #CLK_HALF clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs.
  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // Receiver: checks accepted result items and drives ready with stalls.
  initial begin
    int unsigned hold_left;
    int unsigned hold_seen;
    distance_result_t got;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(posedge clk_i);
      if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
        got.avg_raw = out_if.avg_raw;
        got.voltage_mv = out_if.voltage_mv;
        got.distance_q8 = out_if.distance_q8;
        got.status = range_status_e'(out_if.range_status);
        sb.check_result(got);
      end
      if (hold_seen != hold_reqs) begin
        hold_seen = hold_reqs;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (steady) begin
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // Offers one sample item, with random idle cycles ahead of it.
  task automatic send_sample(input logic [SAMPLE_W-1:0] sample);
    if (!steady) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        in_if.valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_if.valid <= 1'b1;
    in_if.adc_sample <= sample;
    @(posedge clk_i);
    while (in_if.ready !== 1'b1) @(posedge clk_i);
    sb.note_sample(sample);
  endtask

  // Drops valid and waits until every predicted item is out and the block is quiet.
  task automatic drain_results();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Register write: setup cycle, then access cycle until pready.
  task automatic apb_write(input logic [APB_ADDR_W-1:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (pready !== 1'b1) @(posedge clk_i);
    if (addr == AVG_COUNT_ADDR) begin
      sb.write_avg_count(data);
    end
    settings_used++;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  // Mostly samples whose averages land on the calibration curve, some at the clamps.
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 30) return SAMPLE_W'($urandom_range(0, 4095));
    if (r < 80) return SAMPLE_W'($urandom_range(360, 2400));
    if (r < 90) return SAMPLE_W'($urandom_range(0, 420));
    return SAMPLE_W'($urandom_range(2300, 4095));
  endfunction

  // Main stimulus.
  initial begin
    logic [SAMPLE_W-1:0] edge_samples[17];
    int unsigned phase_counts[8];
    edge_samples = '{12'd0, 12'd4095, 12'd372, 12'd373, 12'd409, 12'd410, 12'd411,
                     12'd2345, 12'd2346, 12'd881, 12'd882, 12'h555, 12'hAAA,
                     12'd1000, 12'd1500, 12'd2000, 12'd700};
    phase_counts = '{1, 3, 255, 2, 0, 7, 1, 5};
    phase_counts[7] = $urandom_range(2, 12);

    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_if.valid = 1'b0;
    in_if.adc_sample = '0;
    out_if.ready = 1'b0;
    steady = 1'b0;
    hold_reqs = 0;
    settings_used = 0;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Field extremes and the clamp thresholds, one sample per result.
    foreach (edge_samples[i]) send_sample(edge_samples[i]);
    drain_results();

    // A zero count behaves as a count of one.
    apb_write(AVG_COUNT_ADDR, 32'd0);
    send_sample(12'd4095);
    send_sample(12'd3);
    drain_results();

    // Lowering the count below the samples held closes the group on the next one.
    apb_write(AVG_COUNT_ADDR, 32'd8);
    repeat (5) send_sample(pick_sample());
    drain_results();
    apb_write(AVG_COUNT_ADDR, 32'd2);
    send_sample(pick_sample());
    drain_results();

    // A write to an address with no register leaves the count alone.
    apb_write(UNUSED_ADDR, 32'd3);
    send_sample(12'd1234);
    send_sample(12'd2222);
    drain_results();

    // Random phases over several averaging settings.
    foreach (phase_counts[p]) begin
      apb_write(AVG_COUNT_ADDR, 32'(phase_counts[p]));
      steady = (p == 3);
      if (p == 0) hold_reqs++;
      for (int i = 0; i < ((phase_counts[p] == 255) ? 255 : PHASE_ITEMS); i++) begin
        // Sender waits for all results once, partway through a phase.
        if (p == 5 && i == PHASE_ITEMS / 2) begin
          in_if.valid <= 1'b0;
          @(posedge clk_i);
          while (sb.pending() != 0) @(posedge clk_i);
        end
        send_sample(pick_sample());
      end
      drain_results();
    end

    steady = 1'b0;
    sb.flush_check();
    $display("Sent %0d samples over %0d register writes; checked %0d results",
             sb.samples_seen, settings_used, sb.results_seen);
    $display("Results by range: %0d interpolated, %0d near clamp, %0d far clamp",
             sb.status_hits[RANGE_INTERP], sb.status_hits[RANGE_NEAR],
             sb.status_hits[RANGE_FAR]);
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
